### rtl/btpc_pkg.sv
// shared types and constants for the barometric compensation pipeline
`default_nettype none
package btpc_pkg;
  localparam int DivBits = 64;
  localparam logic [1:0] CFG_TEMP = 2'd0;
  localparam logic [1:0] CFG_PLOW = 2'd1;
  localparam logic [1:0] CFG_PHIGH = 2'd2;
  localparam logic [1:0] CFG_P9 = 2'd3;

  // one division step carried down the cell chain
  typedef struct packed {
    logic        vld;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] den;
    logic        neg;
    logic        inv;
    logic [31:0] tc;
    logic [31:0] tf;
  } div_cell_t;

  // restoring division step on magnitudes, one quotient bit per cell
  function automatic div_cell_t div_step(input div_cell_t c);
    div_cell_t    o;
    logic [64:0]  trial;
    o = c;
    trial = {c.rem, c.quo[63]} - {1'b0, c.den};
    if (!trial[64]) begin
      o.rem = trial[63:0];
      o.quo = {c.quo[62:0], 1'b1};
    end else begin
      o.rem = {c.rem[62:0], c.quo[63]};
      o.quo = {c.quo[62:0], 1'b0};
    end
    return o;
  endfunction
endpackage
`default_nettype wire

### rtl/btpc_div_cell.sv
// one cell of the divider chain: a registered division step
`default_nettype none
module btpc_div_cell
  import btpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire div_cell_t d_in,
  output div_cell_t      d_out
);
  div_cell_t cell_r, cell_nxt;
  always_comb begin
    cell_nxt = div_step(d_in);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end
  assign d_out = cell_r;
endmodule
`default_nettype wire

### rtl/baro_temp_pressure_compensate.sv
// top level: compensation pipeline with a 64-cell divider chain
// Each reading pair passes through 73 register stages: five stages for the temperature and
// pressure prefactors, then the 64-bit division through a chain of 64 cells, one quotient
// bit each, then four stages for the pressure correction. One transaction is accepted per
// cycle unless a valid output is stalled; a stall on the output freezes the whole pipeline,
// so the input stalls exactly while a valid output is stalled.
`default_nettype none
module baro_temp_pressure_compensate
  import btpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [19:0]        in_raw_temperature,
  input  wire logic [19:0]        in_raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_temperature_centi,
  output logic signed [31:0]      out_fine_temperature,
  output logic [31:0]             out_pressure_q24_8,
  output logic                    out_pressure_invalid
);
  logic [47:0] tco_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tco_r <= '0; plo_r <= '0; phi_r <= '0; p9_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP:  tco_r <= cfg_wdata[47:0];
        CFG_PLOW:  plo_r <= cfg_wdata;
        CFG_PHIGH: phi_r <= cfg_wdata;
        CFG_P9:    p9_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [63:0] t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t2 = 64'(signed'(tco_r[31:16]));
  assign t3 = 64'(signed'(tco_r[47:32]));
  assign p1 = {48'd0, plo_r[15:0]};
  assign p2 = 64'(signed'(plo_r[31:16]));
  assign p3 = 64'(signed'(plo_r[47:32]));
  assign p4 = 64'(signed'(plo_r[63:48]));
  assign p5 = 64'(signed'(phi_r[15:0]));
  assign p6 = 64'(signed'(phi_r[31:16]));
  assign p7 = 64'(signed'(phi_r[47:32]));
  assign p8 = 64'(signed'(phi_r[63:48]));
  assign p9 = 64'(signed'(p9_r));

  // stage 1: temperature products
  logic s1_v_r;
  logic signed [63:0] s1_a_r, s1_bb_r;
  logic [19:0] s1_p_r;
  logic signed [17:0] a_c;
  logic signed [16:0] b_c;
  assign a_c = signed'({1'b0, in_raw_temperature[19:3]}) - signed'({1'b0, tco_r[15:0], 1'b0});
  assign b_c = signed'({1'b0, in_raw_temperature[19:4]}) - signed'({1'b0, tco_r[15:0]});
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r <= (64'(a_c) * t2) >>> 11;
      s1_bb_r <= (64'(b_c) * 64'(b_c)) >>> 12;
      s1_p_r <= in_raw_pressure;
    end
  end

  // stage 2: fine temperature
  logic s2_v_r;
  logic signed [31:0] s2_tf_r;
  logic [19:0] s2_p_r;
  logic signed [63:0] tv2_c, tsum_c;
  assign tv2_c = (s1_bb_r * t3) >>> 14;
  assign tsum_c = s1_a_r + tv2_c;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_tf_r <= tsum_c[31:0];
      s2_p_r <= s1_p_r;
    end
  end

  // stage 3: v1 and its square, temperature in centidegrees
  logic s3_v_r;
  logic signed [63:0] s3_v1_r, s3_sq_r;
  logic signed [31:0] s3_tf_r, s3_tc_r;
  logic [19:0] s3_p_r;
  logic signed [63:0] v1_c, tf64_c, tc_c;
  logic signed [32:0] v1n_c;
  assign tf64_c = 64'(s2_tf_r);
  assign v1n_c = 33'(s2_tf_r) - 33'sd128000;
  assign v1_c = 64'(v1n_c);
  assign tc_c = (tf64_c * 64'sd5 + 64'sd128) >>> 8;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_v1_r <= v1_c;
      s3_sq_r <= 64'(v1n_c) * 64'(v1n_c);
      s3_tf_r <= s2_tf_r;
      s3_tc_r <= tc_c[31:0];
      s3_p_r <= s2_p_r;
    end
  end

  // stage 4: coefficient products
  logic s4_v_r;
  logic signed [63:0] s4_v2_r, s4_va_r;
  logic signed [31:0] s4_tf_r, s4_tc_r;
  logic [19:0] s4_p_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_v2_r <= s3_sq_r * p6 + ((s3_v1_r * p5) <<< 17) + (p4 <<< 35);
      s4_va_r <= ((s3_sq_r * p3) >>> 8) + ((s3_v1_r * p2) <<< 12);
      s4_tf_r <= s3_tf_r;
      s4_tc_r <= s3_tc_r;
      s4_p_r <= s3_p_r;
    end
  end

  // stage 5: divisor and dividend
  logic s5_v_r;
  logic signed [63:0] s5_den_r, s5_num_r;
  logic signed [31:0] s5_tf_r, s5_tc_r;
  logic signed [63:0] q0_c;
  assign q0_c = 64'sd1048576 - 64'(s4_p_r);
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_den_r <= (((64'sd1 <<< 47) + s4_va_r) * p1) >>> 33;
      s5_num_r <= ((q0_c <<< 31) - s4_v2_r) * 64'sd3125;
      s5_tf_r <= s4_tf_r;
      s5_tc_r <= s4_tc_r;
    end
  end

  // magnitudes into the divider chain
  div_cell_t chain [0:DivBits];
  always_comb begin
    chain[0].vld = s5_v_r;
    chain[0].rem = '0;
    chain[0].quo = s5_num_r[63] ? 64'(-s5_num_r) : s5_num_r;
    chain[0].den = s5_den_r[63] ? 64'(-s5_den_r) : s5_den_r;
    chain[0].neg = s5_num_r[63] ^ s5_den_r[63];
    chain[0].inv = (s5_den_r == 64'sd0);
    chain[0].tc = s5_tc_r;
    chain[0].tf = s5_tf_r;
  end

  for (genvar i = 0; i < DivBits; i++) begin : g_div
    btpc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(chain[i]), .d_out(chain[i+1])
    );
  end

  // stage a: signed quotient and shifted copy
  div_cell_t dq;
  assign dq = chain[DivBits];
  logic sa_v_r, sa_inv_r;
  logic signed [63:0] sa_q_r, sa_qs_r;
  logic signed [31:0] sa_tf_r, sa_tc_r;
  logic signed [63:0] qs_c;
  assign qs_c = dq.neg ? 64'(-dq.quo) : dq.quo;
  always_ff @(posedge clk) begin
    if (!rst_n) sa_v_r <= 1'b0;
    else if (en) sa_v_r <= dq.vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sa_q_r <= qs_c;
      sa_qs_r <= qs_c >>> 13;
      sa_inv_r <= dq.inv;
      sa_tf_r <= dq.tf;
      sa_tc_r <= dq.tc;
    end
  end

  // stage b: first products of the correction
  logic sb_v_r, sb_inv_r;
  logic signed [63:0] sb_q_r, sb_qs_r, sb_m_r, sb_c2_r;
  logic signed [31:0] sb_tf_r, sb_tc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sb_v_r <= 1'b0;
    else if (en) sb_v_r <= sa_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb_m_r <= p9 * sa_qs_r;
      sb_c2_r <= (p8 * sa_q_r) >>> 19;
      sb_q_r <= sa_q_r;
      sb_qs_r <= sa_qs_r;
      sb_inv_r <= sa_inv_r;
      sb_tf_r <= sa_tf_r;
      sb_tc_r <= sa_tc_r;
    end
  end

  // stage c: 32-bit partial products of the low half of the p9 term
  logic sc_v_r, sc_inv_r;
  logic [63:0] sc_ll_r;
  logic [31:0] sc_lh_r, sc_hl_r;
  logic signed [63:0] sc_qc_r;
  logic signed [31:0] sc_tf_r, sc_tc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sc_v_r <= 1'b0;
    else if (en) sc_v_r <= sb_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sc_ll_r <= {32'd0, sb_m_r[31:0]} * {32'd0, sb_qs_r[31:0]};
      sc_lh_r <= sb_m_r[31:0] * sb_qs_r[63:32];
      sc_hl_r <= sb_m_r[63:32] * sb_qs_r[31:0];
      sc_qc_r <= sb_q_r + sb_c2_r;
      sc_inv_r <= sb_inv_r;
      sc_tf_r <= sb_tf_r;
      sc_tc_r <= sb_tc_r;
    end
  end

  // stage d: output register
  logic out_v_r, out_inv_r;
  logic [31:0] out_p_r;
  logic signed [31:0] out_tf_r, out_tc_r;
  logic [63:0] c1p_c;
  logic signed [63:0] c1_c, p_c;
  assign c1p_c = {sc_lh_r + sc_hl_r, 32'd0} + sc_ll_r;
  assign c1_c = signed'(c1p_c) >>> 25;
  assign p_c = ((sc_qc_r + c1_c) >>> 8) + (p7 <<< 4);
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= sc_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_p_r <= sc_inv_r ? 32'hFFFF_FFFF : p_c[31:0];
      out_inv_r <= sc_inv_r;
      out_tf_r <= sc_tf_r;
      out_tc_r <= sc_tc_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_pressure_q24_8 = out_p_r;
  assign out_pressure_invalid = out_inv_r;
  assign out_fine_temperature = out_tf_r;
  assign out_temperature_centi = out_tc_r;

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pressure_q24_8) && out_valid)
    else $error("output changed while stalled");
  a_inv_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_invalid |-> out_pressure_q24_8 == 32'hFFFF_FFFF)
    else $error("invalid pressure not all ones");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
endmodule
`default_nettype wire

### dv/tb_baro_temp_pressure_compensate.sv
// testbench for baro_temp_pressure_compensate: directed table, random readings, self-checking
`timescale 1ns / 100ps
module tb_baro_temp_pressure_compensate
  import btpc_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] tf;
    logic [31:0]        pr;
    logic               inv;
  } comp_t;

  typedef struct packed {
    logic [47:0] tcoef;
    logic [63:0] plow;
    logic [63:0] phigh;
    logic [15:0] p9;
  } coef_set_t;

  typedef struct packed {
    int          set_sel;
    logic [19:0] rt;
    logic [19:0] rp;
    logic        typed;
    comp_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_TEMP;
  logic [63:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_temperature_centi;
  logic signed [31:0] out_fine_temperature;
  logic [31:0] out_pressure_q24_8;
  logic out_pressure_invalid;

  baro_temp_pressure_compensate DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // coefficient copies held by the predictor
  logic [47:0] temp_coef = '0;
  logic [63:0] press_low = '0;
  logic [63:0] press_high = '0;
  logic [15:0] press_nine = '0;

  comp_t pending_results[$];
  int error_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_req = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    error_count++;
  endtask

  function automatic logic [63:0] asr(input logic [63:0] v, input int s);
    logic signed [63:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(input logic [19:0] rt, input logic [19:0] rp);
    logic [63:0] adt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, tv1, tv2, tf, tc, v1, v2, q, num, ua, ub, quo, c1, c2, pr;
    logic na, nb;
    comp_t r;
    adt = {44'b0, rt};
    t1 = {48'b0, temp_coef[15:0]};
    t2 = sx16(temp_coef[31:16]);
    t3 = sx16(temp_coef[47:32]);
    p1 = {48'b0, press_low[15:0]};
    p2 = sx16(press_low[31:16]);
    p3 = sx16(press_low[47:32]);
    p4 = sx16(press_low[63:48]);
    p5 = sx16(press_high[15:0]);
    p6 = sx16(press_high[31:16]);
    p7 = sx16(press_high[47:32]);
    p8 = sx16(press_high[63:48]);
    p9 = sx16(press_nine);
    a = (adt >> 3) - (t1 << 1);
    tv1 = asr(a * t2, 11);
    b = (adt >> 4) - t1;
    tv2 = asr(asr(b * b, 12) * t3, 14);
    tf = tv1 + tv2;
    tf = {{32{tf[31]}}, tf[31:0]};
    tc = asr(tf * 64'd5 + 64'd128, 8);
    v1 = tf - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr(((64'd1 << 47) + v1) * p1, 33);
    r.tc = tc[31:0];
    r.tf = tf[31:0];
    if (v1 == 64'd0) begin
      r.pr = 32'hFFFF_FFFF;
      r.inv = 1'b1;
    end else begin
      q = 64'd1048576 - {44'b0, rp};
      num = ((q << 31) - v2) * 64'd3125;
      na = num[63];
      nb = v1[63];
      ua = na ? -num : num;
      ub = nb ? -v1 : v1;
      quo = ua / ub;
      q = (na != nb) ? -quo : quo;
      c1 = asr(p9 * asr(q, 13) * asr(q, 13), 25);
      c2 = asr(p8 * q, 19);
      pr = asr(q + c1 + c2, 8) + (p7 << 4);
      r.pr = pr[31:0];
      r.inv = 1'b0;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_TEMP: begin
        temp_coef = val[47:0];
      end
      CFG_PLOW: begin
        press_low = val;
      end
      CFG_PHIGH: begin
        press_high = val;
      end
      default: begin
        press_nine = val[15:0];
      end
    endcase
  endtask

  // coefficients change only with the pipe drained
  task automatic load_coefs(input coef_set_t cs);
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    write_reg(CFG_TEMP, {16'b0, cs.tcoef});
    write_reg(CFG_PLOW, cs.plow);
    write_reg(CFG_PHIGH, cs.phigh);
    write_reg(CFG_P9, {{48{cs.p9[15]}}, cs.p9});
    cfg_we <= 1'b0;
  endtask

  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp,
                              input logic typed, input comp_t res);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(typed ? res : compensate(rt, rp));
  endtask

  function automatic coef_set_t random_coefs(input int flavor);
    coef_set_t cs;
    cs.tcoef = 48'({$urandom(), $urandom()});
    cs.plow = {$urandom(), $urandom()};
    cs.phigh = {$urandom(), $urandom()};
    cs.p9 = 16'($urandom());
    if (flavor == 0) begin
      // near a real part: small perturbation of typical trimming
      cs.tcoef = {16'hFC18 + 16'($urandom_range(40)), 16'd26435 + 16'($urandom_range(500)),
                  16'd27504 + 16'($urandom_range(500))};
      cs.plow = {16'd2855, 16'd3024, 16'hD643 + 16'($urandom_range(100)),
                 16'd36477 + 16'($urandom_range(200))};
      cs.phigh = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140 + 16'($urandom_range(50))};
      cs.p9 = 16'd6000 + 16'($urandom_range(100));
    end else if (flavor == 1) begin
      cs.plow[15:0] = 16'd0;
    end
    return cs;
  endfunction

  // receiver: random stall, plus one long hold-off counted here
  int hold_count = 0;
  logic hold_seen = 1'b0;
  always @(posedge clk) begin
    hold_seen <= hold_req;
    if (hold_req && !hold_seen) begin
      hold_count <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(negedge clk) begin
    comp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_pressure_q24_8), 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_temperature_centi !== e.tc)
          report_mismatch("temperature_centi", 64'(out_temperature_centi), 64'(e.tc));
        if (out_fine_temperature !== e.tf)
          report_mismatch("fine_temperature", 64'(out_fine_temperature), 64'(e.tf));
        if (out_pressure_q24_8 !== e.pr)
          report_mismatch("pressure_q24_8", 64'(out_pressure_q24_8), 64'(e.pr));
        if (out_pressure_invalid !== e.inv)
          report_mismatch("pressure_invalid", 64'(out_pressure_invalid), 64'(e.inv));
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  coef_set_t coef_sets[4];
  dir_row_t dir_rows[20];
  localparam comp_t ZeroCoefRes = '{tc: 32'sd0, tf: 32'sd0, pr: 32'hFFFF_FFFF, inv: 1'b1};
  localparam comp_t Untyped = '0;

  initial begin
    int cur_set;
    logic [19:0] rt, rp;
    coef_sets[0] = '0;
    coef_sets[1] = '{tcoef: {16'hFC18, 16'd26435, 16'd27504},
                     plow: {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                     phigh: {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, p9: 16'd6000};
    coef_sets[2] = '{tcoef: '1, plow: '1, phigh: '1, p9: '1};
    coef_sets[3] = '{tcoef: {16'h8000, 16'h8000, 16'hFFFF}, plow: {16'h7FFF, 16'h8000,
                     16'h7FFF, 16'hFFFF}, phigh: {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                     p9: 16'h8000};
    // all coefficients zero after reset: divisor is zero
    dir_rows[0] = '{0, 20'h00000, 20'h00000, 1'b1, ZeroCoefRes};
    dir_rows[1] = '{0, 20'hFFFFF, 20'hFFFFF, 1'b1, ZeroCoefRes};
    dir_rows[2] = '{0, 20'hFFFFF, 20'h00000, 1'b1, ZeroCoefRes};
    dir_rows[3] = '{0, 20'h00000, 20'hFFFFF, 1'b1, ZeroCoefRes};
    dir_rows[4] = '{0, 20'hAAAAA, 20'h55555, 1'b1, ZeroCoefRes};
    dir_rows[5] = '{1, 20'd519888, 20'd415148, 1'b0, Untyped};
    dir_rows[6] = '{1, 20'h00000, 20'h00000, 1'b0, Untyped};
    dir_rows[7] = '{1, 20'hFFFFF, 20'hFFFFF, 1'b0, Untyped};
    dir_rows[8] = '{1, 20'hFFFFF, 20'h00000, 1'b0, Untyped};
    dir_rows[9] = '{1, 20'h00000, 20'hFFFFF, 1'b0, Untyped};
    dir_rows[10] = '{1, 20'h80000, 20'h7FFFF, 1'b0, Untyped};
    dir_rows[11] = '{2, 20'h00000, 20'h00000, 1'b0, Untyped};
    dir_rows[12] = '{2, 20'hFFFFF, 20'hFFFFF, 1'b0, Untyped};
    dir_rows[13] = '{2, 20'h55555, 20'hAAAAA, 1'b0, Untyped};
    dir_rows[14] = '{2, 20'h7FFFF, 20'h00001, 1'b0, Untyped};
    dir_rows[15] = '{3, 20'h00000, 20'h00000, 1'b0, Untyped};
    dir_rows[16] = '{3, 20'hFFFFF, 20'hFFFFF, 1'b0, Untyped};
    dir_rows[17] = '{3, 20'hFFFFF, 20'h00000, 1'b0, Untyped};
    dir_rows[18] = '{3, 20'h00000, 20'hFFFFF, 1'b0, Untyped};
    dir_rows[19] = '{3, 20'h12345, 20'h6789A, 1'b0, Untyped};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_set = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_sel != cur_set) begin
        in_valid <= 1'b0;
        cur_set = dir_rows[i].set_sel;
        load_coefs(coef_sets[cur_set]);
      end
      send_reading(dir_rows[i].rt, dir_rows[i].rp, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < 9; ph++) begin
      in_valid <= 1'b0;
      tx_idle_pct = (ph < 3) ? 12 : (ph < 6) ? 54 : 0;
      rx_idle_pct = (ph < 3) ? 54 : (ph < 6) ? 12 : 0;
      load_coefs(random_coefs(ph % 3 == 2 ? 2 : (ph == 4 ? 1 : 0)));
      if (ph == 6) hold_req <= 1'b1;
      for (int n = 0; n < 95; n++) begin
        rt = 20'($urandom());
        rp = 20'($urandom());
        if ($urandom_range(9) == 0) rt = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
        if ($urandom_range(9) == 0) rp = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
        send_reading(rt, rp, 1'b0, Untyped);
      end
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
